/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/rbe_pkg.sv */
`timescale 1ns / 1ps

package rbe_pkg;

  // default coder geometry
  localparam int SCALE_BITS_DEF       = 12;
  localparam int LOWER_BOUND_BITS_DEF = 23;

  // field widths
  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int WEIGHT_W = 13;
  localparam int STATE_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int IN_DATA_W = ((SYM_W + WEIGHT_W + 7) / 8) * 8;

  typedef logic [CMD_W-1:0] cmd_t;

  // command codes
  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_START  = 2'd1;
  localparam cmd_t CMD_ENCODE = 2'd2;
  localparam cmd_t CMD_FLUSH  = 2'd3;

endpackage

/* design/rans_byte_encoder_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   dir  tdata                                tuser        tlast
// s_axis    in   [7:0] symbol, [20:8] weight, pad     [1:0] cmd    -
// m_axis    out  [7:0] out_byte                       [0] flush    run_last
//
// load and start finish on acceptance; a zero-weight encode ends at the renorm check.
// encode: accept cycle with table read, one renormalization byte per cycle (at
// most two), a divider load cycle, LOWER_BOUND_BITS - SCALE_BITS + 8 restoring
// divider steps (19 at the defaults) and a rebase cycle.
// flush: accept cycle, then four state bytes, one per cycle. a stalled m_axis
// holds the sequencer in place; sync reset sets the lower bound, clears the running sum
module rans_byte_encoder_core #(
  parameter int SCALE_BITS       = rbe_pkg::SCALE_BITS_DEF,
  parameter int LOWER_BOUND_BITS = rbe_pkg::LOWER_BOUND_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rbe_pkg::IN_DATA_W-1:0] s_axis_tdata,  // symbol, weight, zero pad
  input  logic [rbe_pkg::CMD_W-1:0]    s_axis_tuser,  // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rbe_pkg::BYTE_W-1:0]   m_axis_tdata,  // out_byte
  output logic                         m_axis_tlast,  // run_last
  output logic [0:0]                   m_axis_tuser   // flush_byte
);
  import rbe_pkg::*;

  // renormalization bound is weight << RENORM_SHIFT; also the quotient width
  localparam int RENORM_SHIFT = LOWER_BOUND_BITS - SCALE_BITS + 8;
  localparam int CMP_W = (WEIGHT_W + RENORM_SHIFT > STATE_W) ?
                         (WEIGHT_W + RENORM_SHIFT) : STATE_W;
  localparam int CNT_W = $clog2(RENORM_SHIFT + 1);
  localparam logic [CNT_W-1:0]   DIV_STEPS   = CNT_W'(RENORM_SHIFT);
  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LOWER_BOUND_BITS;
  localparam int TBL_DEPTH = 1 << SYM_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RENORM = 3'd1;
  localparam logic [2:0] ST_DIVIDE = 3'd2;
  localparam logic [2:0] ST_REBASE = 3'd3;
  localparam logic [2:0] ST_FLUSH  = 3'd4;

  logic [2:0] state, state_next;

  // input fields
  cmd_t                in_cmd;
  logic [SYM_W-1:0]    in_symbol;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_xfer;

  assign in_cmd    = s_axis_tuser;
  assign in_symbol = s_axis_tdata[SYM_W-1:0];
  assign in_weight = s_axis_tdata[SYM_W+WEIGHT_W-1:SYM_W];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // frequency and cumulative base tables, registered read
  logic [WEIGHT_W-1:0] weight_mem [TBL_DEPTH];
  logic [WEIGHT_W-1:0] base_mem   [TBL_DEPTH];
  logic [WEIGHT_W-1:0] weight_rd, base_rd;

  logic [WEIGHT_W-1:0] running_sum, running_sum_next, load_base;
  logic [STATE_W-1:0]  coder_state, coder_state_next;

  // divider registers
  logic [WEIGHT_W-1:0]     rem;
  logic [RENORM_SHIFT-1:0] quo;
  logic [CNT_W-1:0]        div_cnt;
  logic [WEIGHT_W:0]       rem_shift, rem_sub;
  logic                    rem_ge;
  logic [WEIGHT_W-1:0]     rem_new;
  logic                    div_load, div_step;

  // bound compares: current state and state after dropping one byte
  logic [CMP_W-1:0] x_max;
  logic             x_ge, x_shift_ge;

  logic [STATE_W-1:0] rebase_sum;

  // output slot
  logic              out_free;
  logic              emit, emit_last, emit_flush;
  logic [BYTE_W-1:0] emit_byte;
  logic [1:0]        flush_cnt;

  assign load_base = (in_symbol == '0) ? '0 : running_sum;

  assign x_max      = CMP_W'(weight_rd) << RENORM_SHIFT;
  assign x_ge       = CMP_W'(coder_state) >= x_max;
  assign x_shift_ge = CMP_W'(coder_state >> BYTE_W) >= x_max;

  assign rem_shift = {rem, quo[RENORM_SHIFT-1]};
  assign rem_sub   = rem_shift - {1'b0, weight_rd};
  assign rem_ge    = rem_shift >= {1'b0, weight_rd};
  assign rem_new   = rem_ge ? rem_sub[WEIGHT_W-1:0] : rem_shift[WEIGHT_W-1:0];

  assign rebase_sum = (STATE_W'(quo) << SCALE_BITS) + STATE_W'(rem) + STATE_W'(base_rd);

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next       = state;
    coder_state_next = coder_state;
    running_sum_next = running_sum;
    emit             = 1'b0;
    emit_last        = 1'b0;
    emit_flush       = 1'b0;
    emit_byte        = coder_state[BYTE_W-1:0];
    div_load         = 1'b0;
    div_step         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_LOAD:   running_sum_next = load_base + in_weight;
            CMD_START:  coder_state_next = LOWER_BOUND;
            CMD_ENCODE: state_next = ST_RENORM;
            CMD_FLUSH:  state_next = ST_FLUSH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_RENORM: begin
        if (weight_rd == '0) begin
          // zero-frequency symbol is skipped
          state_next = ST_IDLE;
        end else if (x_ge) begin
          if (out_free) begin
            emit             = 1'b1;
            emit_last        = !x_shift_ge;
            coder_state_next = coder_state >> BYTE_W;
          end
        end else begin
          div_load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        div_step = 1'b1;
        if (div_cnt == CNT_W'(1)) begin
          state_next = ST_REBASE;
        end
      end
      ST_REBASE: begin
        coder_state_next = rebase_sum;
        state_next       = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_flush       = 1'b1;
          emit_last        = (flush_cnt == 2'd3);
          coder_state_next = coder_state >> BYTE_W;
          if (flush_cnt == 2'd3) begin
            coder_state_next = LOWER_BOUND;
            state_next       = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      coder_state   <= LOWER_BOUND;
      running_sum   <= '0;
      flush_cnt     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      coder_state <= coder_state_next;
      running_sum <= running_sum_next;
      if (emit && emit_flush) begin
        flush_cnt <= flush_cnt + 2'd1;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // table write on load, table read on every accepted transfer
  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == CMD_LOAD) begin
      weight_mem[in_symbol] <= in_weight;
      base_mem[in_symbol]   <= load_base;
    end
    if (in_xfer) begin
      weight_rd <= weight_mem[in_symbol];
      base_rd   <= base_mem[in_symbol];
    end
  end

  // restoring divider: the state is below weight << RENORM_SHIFT here, so the
  // high part already sits below the weight and only RENORM_SHIFT steps remain
  always_ff @(posedge clk) begin
    if (div_load) begin
      rem     <= WEIGHT_W'(coder_state >> RENORM_SHIFT);
      quo     <= coder_state[RENORM_SHIFT-1:0];
      div_cnt <= DIV_STEPS;
    end else if (div_step) begin
      rem     <= rem_new;
      quo     <= {quo[RENORM_SHIFT-2:0], rem_ge};
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata    <= emit_byte;
      m_axis_tlast    <= emit_last;
      m_axis_tuser[0] <= emit_flush;
    end
  end

  `CHK_ASSERT(a_rem_below_weight, (state == ST_DIVIDE) |-> (rem < weight_rd), "divider remainder reached the weight")
  `CHK_ASSERT(a_div_state_in_range, (state == ST_DIVIDE) |-> !x_ge, "division started above the renormalization bound")
  `CHK_ASSERT(a_flush_restores_bound, ($past(state) == ST_FLUSH && state == ST_IDLE) |-> (coder_state == LOWER_BOUND), "flush did not restore the lower bound")
  `CHK_ASSERT_ALWAYS(a_reset_clears, rst |=> (!m_axis_tvalid && coder_state == LOWER_BOUND && state == ST_IDLE), "reset left the coder active")

endmodule

/* tb/rans_byte_encoder_core_chk.sv */
`timescale 1ns / 1ps

// watches both channels, predicts the coded byte stream and compares it
module rans_byte_encoder_core_chk
  import rbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  input  logic [CMD_W-1:0]       s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [BYTE_W-1:0]      m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic [0:0]             m_axis_tuser,
  output int                     bytes_due,
  output int                     mismatches
);

  localparam int          SCALE_BITS  = SCALE_BITS_DEF;
  localparam logic [63:0] LOWER_BOUND = 64'd1 << LOWER_BOUND_BITS_DEF;
  localparam int          MAX_BYTES   = 4;
  localparam int          BUF_DEPTH   = 1024;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              flush;
  } coded_byte_t;

  // expected bytes, in order, as a ring buffer
  coded_byte_t          coded_buf [BUF_DEPTH];
  int                   wr_ptr;
  int                   rd_ptr;
  logic [STATE_W-1:0]   coder_x;
  logic [WEIGHT_W-1:0]  run_sum;
  logic [WEIGHT_W-1:0]  freq_tab [256];
  logic [WEIGHT_W-1:0]  base_tab [256];

  initial begin
    bytes_due  = 0;
    mismatches = 0;
    wr_ptr     = 0;
    rd_ptr     = 0;
    for (int i = 0; i < 256; i++) begin
      freq_tab[i] = '0;
      base_tab[i] = '0;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("%0t ns: coded byte %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_byte(input coded_byte_t cb);
    coded_buf[wr_ptr % BUF_DEPTH] = cb;
    wr_ptr++;
  endtask

  // one command in, its coded bytes appended to the queue
  task automatic rans_predict(input cmd_t cmd, input logic [SYM_W-1:0] sym,
                              input logic [WEIGHT_W-1:0] wt);
    logic [63:0] x;
    logic [63:0] x_max;
    logic [63:0] f;
    int          n;
    coded_byte_t cb;
    n = 0;
    case (cmd)
      CMD_LOAD: begin
        if (sym == 0)
          run_sum = '0;
        freq_tab[sym] = wt;
        base_tab[sym] = run_sum;
        run_sum       = run_sum + wt;
      end
      CMD_START: coder_x = LOWER_BOUND[STATE_W-1:0];
      CMD_ENCODE: begin
        f = 64'(freq_tab[sym]);
        if (f != 0) begin
          x     = 64'(coder_x);
          x_max = ((LOWER_BOUND >> SCALE_BITS) << 8) * f;
          while (x >= x_max && n < MAX_BYTES) begin
            cb.data  = x[7:0];
            cb.last  = ((x >> 8) < x_max) || (n == MAX_BYTES - 1);
            cb.flush = 1'b0;
            queue_byte(cb);
            n++;
            x = x >> 8;
          end
          x       = ((x / f) << SCALE_BITS) + (x % f) + 64'(base_tab[sym]);
          coder_x = x[STATE_W-1:0];
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          cb.data  = coder_x[8*i +: 8];
          cb.last  = (i == 3);
          cb.flush = 1'b1;
          queue_byte(cb);
        end
        coder_x = LOWER_BOUND[STATE_W-1:0];
      end
    endcase
  endtask

  always @(posedge clk) begin
    coded_byte_t want;
    if (rst) begin
      coder_x = LOWER_BOUND[STATE_W-1:0];
      run_sum = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        rans_predict(s_axis_tuser, s_axis_tdata[SYM_W-1:0],
                     s_axis_tdata[SYM_W +: WEIGHT_W]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_ptr == rd_ptr) begin
          report_mismatch("unexpected", int'(m_axis_tdata), -1);
        end else begin
          want = coded_buf[rd_ptr % BUF_DEPTH];
          rd_ptr++;
          if (m_axis_tdata !== want.data)
            report_mismatch("value", int'(m_axis_tdata), int'(want.data));
          if (m_axis_tlast !== want.last)
            report_mismatch("run_last", int'(m_axis_tlast), int'(want.last));
          if (m_axis_tuser[0] !== want.flush)
            report_mismatch("flush flag", int'(m_axis_tuser[0]), int'(want.flush));
        end
      end
    end
    bytes_due = wr_ptr - rd_ptr;
  end

endmodule

/* tb/rans_byte_encoder_core_tb.sv */
`timescale 1ns / 1ps

module rans_byte_encoder_core_tb;
  import rbe_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = CMD_START;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic [0:0]           m_axis_tuser;
  int                   bytes_due;
  int                   mismatches;

  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;
  int                   items_done = 0;
  bit                   loaded [256];
  int unsigned          sym_weight [256];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rans_byte_encoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rans_byte_encoder_core_chk u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .bytes_due     (bytes_due),
    .mismatches    (mismatches)
  );

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // one command transfer, with random gaps ahead of it
  task automatic send_item(input cmd_t cmd, input logic [SYM_W-1:0] sym,
                           input logic [WEIGHT_W-1:0] wt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - SYM_W - WEIGHT_W){1'b0}}, wt, sym};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      loaded[sym]     = 1'b1;
      sym_weight[sym] = 32'(wt);
    end
    // skipped zero-weight encodes do not count
    if (!(cmd == CMD_ENCODE && sym_weight[sym] == 0))
      items_done++;
  endtask

  // mostly a whole block: table, start, symbols, flush; sometimes loose commands
  task automatic random_block();
    int               n;
    int               left;
    logic [WEIGHT_W-1:0] w;
    logic [SYM_W-1:0] s;
    if ($urandom_range(99) < 85) begin
      n    = $urandom_range(12, 2);
      left = 4096;
      for (int i = 0; i < n; i++) begin
        if (i == n - 1)
          w = WEIGHT_W'(left);
        else
          w = WEIGHT_W'($urandom_range(left - (n - 1 - i), 1));
        left -= int'(w);
        send_item(CMD_LOAD, SYM_W'(i), w);
      end
      send_item(CMD_START, SYM_W'($urandom_range(255)), WEIGHT_W'($urandom_range(8191)));
      repeat ($urandom_range(16, 4))
        send_item(CMD_ENCODE, SYM_W'($urandom_range(n - 1)),
                  WEIGHT_W'($urandom_range(8191)));
      send_item(CMD_FLUSH, SYM_W'($urandom_range(255)), WEIGHT_W'($urandom_range(8191)));
    end else begin
      repeat ($urandom_range(4, 1)) begin
        case ($urandom_range(3))
          0: send_item(CMD_LOAD, SYM_W'($urandom_range(255)),
                       WEIGHT_W'($urandom_range(8191)));
          1: send_item(CMD_START, SYM_W'($urandom_range(255)),
                       WEIGHT_W'($urandom_range(8191)));
          2: begin
            s = SYM_W'($urandom_range(255));
            // never touch an entry that was not loaded
            if (!loaded[s])
              s = 8'd0;
            send_item(CMD_ENCODE, s, WEIGHT_W'($urandom_range(8191)));
          end
          default: send_item(CMD_FLUSH, SYM_W'($urandom_range(255)),
                             WEIGHT_W'($urandom_range(8191)));
        endcase
      end
    end
  endtask

  initial begin
    int target;
    tx_idle_pct = 21;
    rx_idle_pct = 63;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // table with a unit weight, a zero weight, out-of-order loads and sum wrap
    send_item(CMD_LOAD,   8'd0,   13'd1);
    send_item(CMD_LOAD,   8'd1,   13'd0);
    send_item(CMD_LOAD,   8'd2,   13'd4095);
    send_item(CMD_LOAD,   8'd255, 13'd8191);
    send_item(CMD_LOAD,   8'd128, 13'd4096);
    send_item(CMD_LOAD,   8'd127, 13'd2);
    // encode straight after reset, no start
    send_item(CMD_ENCODE, 8'd2,   13'd0);
    send_item(CMD_ENCODE, 8'd0,   13'd8191);
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_ENCODE, 8'd1,   13'd0);
    send_item(CMD_ENCODE, 8'd255, 13'd0);
    send_item(CMD_ENCODE, 8'd128, 13'd0);
    send_item(CMD_ENCODE, 8'd127, 13'd0);
    send_item(CMD_FLUSH,  8'd255, 13'd8191);
    // flush leaves the lower bound, then an explicit start
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_START,  8'd0,   13'd0);
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_ENCODE, 8'd255, 13'd0);
    send_item(CMD_ENCODE, 8'd255, 13'd0);
    send_item(CMD_FLUSH,  8'd0,   13'd0);
    // a load of symbol 0 restarts the running sum
    send_item(CMD_LOAD,   8'd0,   13'd4096);
    send_item(CMD_ENCODE, 8'd0,   13'd0);
    send_item(CMD_FLUSH,  8'd0,   13'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 21; rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      target = items_done + 62;
      while (items_done < target)
        random_block();
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("rans_byte_encoder_core_tb OK");
    else
      $display("rans_byte_encoder_core_tb NOT OK");
    $finish;
  end

  initial begin
    #400_000;
    $display("rans_byte_encoder_core_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/rbe_pkg.sv
design/rans_byte_encoder_core.sv
tb/rans_byte_encoder_core_chk.sv
tb/rans_byte_encoder_core_tb.sv
